### hw/rtl/fapq_pkg.sv
// Shared types, codes and defaults for the FIFO and priority task pool.
package fapq_pkg;

	// Port field widths.
	localparam int ID_W = 16;
	localparam int PRI_W = 8;

	// Parameter defaults for the top level.
	localparam int DEF_FIFO_DEPTH = 16;
	localparam int DEF_TABLE_DEPTH = 16;
	localparam int DEF_ID_WIDTH = 16;

	// Command codes.
	localparam logic [1:0] CMD_PUSH_FIFO = 2'd0;
	localparam logic [1:0] CMD_PUSH_PRIO = 2'd1;
	localparam logic [1:0] CMD_POP_FIFO = 2'd2;
	localparam logic [1:0] CMD_POP_PRIO = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// One input item.
	typedef struct packed {
		logic [1:0] cmd;
		logic [ID_W-1:0] task_id;
		logic [PRI_W-1:0] task_priority;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [ID_W-1:0] out_task_id;
		logic [1:0] status;
		logic fifo_pending;
		logic prio_pending;
	} out_item_t;

	// Request from the control to one store.
	typedef struct packed {
		logic go;
		logic push;
		logic [ID_W-1:0] task_id;
		logic [PRI_W-1:0] task_priority;
	} store_req_t;

	// Completion from one store back to the control.
	typedef struct packed {
		logic done;
		logic [ID_W-1:0] task_id;
		logic [1:0] status;
	} store_rsp_t;

endpackage

### hw/rtl/fifo_and_priority_task_pool_core.sv
// Top level of the task pool: command decode, result register and both stores.
//
//  Channel  Ports                 Direction  Transfer
//  command  start, busy, item     in         start high while busy low
//  result   done, result          out        done high for one cycle
//
// A push passes the request register go_q, the store and the result register done_q;
// a FIFO pop adds one registered memory read. A table pop makes one memory read
// per entry to find the winner, then one per entry to pack the survivors.
// busy drops in the cycle that shows the result, so a new item can follow.
// Reset clears both stores to empty; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fifo_and_priority_task_pool_core #(
	parameter int FIFO_DEPTH = fapq_pkg::DEF_FIFO_DEPTH,
	parameter int TABLE_DEPTH = fapq_pkg::DEF_TABLE_DEPTH,
	parameter int ID_WIDTH = fapq_pkg::DEF_ID_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input fapq_pkg::in_item_t item,
	output logic done,
	output fapq_pkg::out_item_t result
);
	import fapq_pkg::*;

	// Stored identifier width: bits above ID_WIDTH are dropped.
	localparam int IDW = (ID_WIDTH < ID_W) ? ID_WIDTH : ID_W;

	logic busy_q, go_q, tbl_q, push_q;
	logic [ID_W-1:0] id_q, res_id_q;
	logic [PRI_W-1:0] pri_q;
	logic [1:0] res_st_q;
	logic done_q;
	logic accept, tbl_sel, push_sel, sub_done;
	store_req_t fifo_req, tbl_req;
	store_rsp_t fifo_rsp, tbl_rsp;
	logic fifo_nonempty, tbl_nonempty;

	assign accept = start && !busy_q;
	assign sub_done = fifo_rsp.done || tbl_rsp.done;

	// Command decode.
	always_comb begin
		tbl_sel = 1'b0;
		push_sel = 1'b0;
		unique case (item.cmd) inside
			CMD_PUSH_FIFO: push_sel = 1'b1;
			CMD_PUSH_PRIO: begin
				push_sel = 1'b1;
				tbl_sel = 1'b1;
			end
			CMD_POP_PRIO: tbl_sel = 1'b1;
			default: tbl_sel = 1'b0;
		endcase
	end

	// Item capture and busy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			go_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_q <= accept;
			done_q <= sub_done;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (sub_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tbl_q <= tbl_sel;
			push_q <= push_sel;
			id_q <= item.task_id;
			pri_q <= item.task_priority;
		end
		if (sub_done) begin
			res_id_q <= fifo_rsp.done ? fifo_rsp.task_id : tbl_rsp.task_id;
			res_st_q <= fifo_rsp.done ? fifo_rsp.status : tbl_rsp.status;
		end
	end

	// Requests to the two stores.
	always_comb begin
		fifo_req.go = go_q && !tbl_q;
		fifo_req.push = push_q;
		fifo_req.task_id = id_q;
		fifo_req.task_priority = pri_q;
		tbl_req.go = go_q && tbl_q;
		tbl_req.push = push_q;
		tbl_req.task_id = id_q;
		tbl_req.task_priority = pri_q;
	end

	fapq_fifo #(
		.DEPTH(FIFO_DEPTH),
		.IDW(IDW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.req(fifo_req),
		.rsp(fifo_rsp),
		.nonempty(fifo_nonempty)
	);

	fapq_table #(
		.DEPTH(TABLE_DEPTH),
		.IDW(IDW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.req(tbl_req),
		.rsp(tbl_rsp),
		.nonempty(tbl_nonempty)
	);

	// Result: pending flags come from the store state after the step.
	assign busy = busy_q;
	assign done = done_q;
	always_comb begin
		result.out_task_id = res_id_q;
		result.status = res_st_q;
		result.fifo_pending = fifo_nonempty;
		result.prio_pending = tbl_nonempty;
	end

	// A store only completes while an item is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sub_done |-> busy_q)
		else $error("store completed with no item in flight");

	// Only one store works on an item.
	a_one_store: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_rsp.done && tbl_rsp.done))
		else $error("both stores completed together");

	// Each strobe follows exactly one store completion.
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(sub_done))
		else $error("result strobe without a completion");

	// The request pulse lasts one cycle.
	a_go_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |=> !go_q)
		else $error("request pulse held longer than one cycle");

endmodule

### hw/rtl/fapq_fifo.sv
// Plain FIFO of task identifiers held in a synchronous memory.
module fapq_fifo #(
	parameter int DEPTH = 16,
	parameter int IDW = 16
) (
	input logic clk,
	input logic arst_n,
	input fapq_pkg::store_req_t req,
	output fapq_pkg::store_rsp_t rsp,
	output logic nonempty
);
	import fapq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic F_IDLE = 1'b0;
	localparam logic F_READ = 1'b1;

	logic [IDW-1:0] mem [DEPTH];
	logic [IDW-1:0] rd_data_q;
	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic state_q, state_d;
	logic wr_en;

	// Sequencing: pushes and pops on empty finish in the request cycle, other pops wait one read.
	always_comb begin
		rsp = '0;
		wr_en = 1'b0;
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (req.go) begin
					if (req.push) begin
						rsp.done = 1'b1;
						if (count_q == CW'(DEPTH)) begin
							rsp.status = ST_FULL;
						end else begin
							wr_en = 1'b1;
							tail_d = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
							count_d = count_q + 1'b1;
						end
					end else if (count_q == '0) begin
						rsp.done = 1'b1;
						rsp.status = ST_EMPTY;
					end else begin
						state_d = F_READ;
					end
				end
			end
			F_READ: begin
				rsp.done = 1'b1;
				rsp.task_id = ID_W'(rd_data_q);
				head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_d = count_q - 1'b1;
				state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			state_q <= F_IDLE;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
			state_q <= state_d;
		end
	end

	// Storage: one write port at the tail, one registered read at the head.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= req.task_id[IDW-1:0];
		end
		rd_data_q <= mem[head_q];
	end

	assign nonempty = (count_q != '0);

endmodule

### hw/rtl/fapq_table.sv
// Priority table kept in insertion order in a synchronous memory.
module fapq_table #(
	parameter int DEPTH = 16,
	parameter int IDW = 16
) (
	input logic clk,
	input logic arst_n,
	input fapq_pkg::store_req_t req,
	output fapq_pkg::store_rsp_t rsp,
	output logic nonempty
);
	import fapq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = IDW + PRI_W;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_SCAN = 2'd1;
	localparam logic [1:0] T_PACK = 2'd2;

	// Entries 0 .. count-1 are live, oldest first.
	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_data_q;
	logic [CW-1:0] count_q, count_d;
	logic [1:0] state_q, state_d;
	logic [AW-1:0] k_q, k_d, w_q, w_d, rd_addr, wr_addr;
	logic [IDW-1:0] best_id_q, best_id_d;
	logic [PRI_W-1:0] best_pri_q, best_pri_d;
	logic wr_en;
	logic [EW-1:0] wr_data;
	logic [IDW-1:0] d_id;
	logic [PRI_W-1:0] d_pri;
	logic last, keep;

	assign d_id = rd_data_q[EW-1:PRI_W];
	assign d_pri = rd_data_q[PRI_W-1:0];
	assign last = (CW'(k_q) == count_q - CW'(1));
	assign keep = (d_id != best_id_q);

	// A pop scans the live entries for the first highest priority, then
	// packs the entries whose identifier differs back down in order.
	always_comb begin
		rsp = '0;
		wr_en = 1'b0;
		wr_addr = w_q;
		wr_data = rd_data_q;
		rd_addr = '0;
		count_d = count_q;
		state_d = state_q;
		k_d = k_q;
		w_d = w_q;
		best_id_d = best_id_q;
		best_pri_d = best_pri_q;
		unique case (state_q)
			T_IDLE: begin
				if (req.go) begin
					if (req.push) begin
						rsp.done = 1'b1;
						if (count_q == CW'(DEPTH)) begin
							rsp.status = ST_FULL;
						end else begin
							wr_en = 1'b1;
							wr_addr = count_q[AW-1:0];
							wr_data = {req.task_id[IDW-1:0], req.task_priority};
							count_d = count_q + 1'b1;
						end
					end else if (count_q == '0) begin
						rsp.done = 1'b1;
						rsp.status = ST_EMPTY;
					end else begin
						k_d = '0;
						state_d = T_SCAN;
					end
				end
			end
			T_SCAN: begin
				if (k_q == '0 || d_pri > best_pri_q) begin
					best_id_d = d_id;
					best_pri_d = d_pri;
				end
				if (last) begin
					k_d = '0;
					w_d = '0;
					state_d = T_PACK;
				end else begin
					rd_addr = k_q + 1'b1;
					k_d = k_q + 1'b1;
				end
			end
			T_PACK: begin
				if (keep) begin
					wr_en = 1'b1;
					w_d = w_q + 1'b1;
				end
				if (last) begin
					rsp.done = 1'b1;
					rsp.task_id = ID_W'(best_id_q);
					count_d = CW'(w_q) + CW'(keep);
					state_d = T_IDLE;
				end else begin
					rd_addr = k_q + 1'b1;
					k_d = k_q + 1'b1;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			state_q <= T_IDLE;
			k_q <= '0;
			w_q <= '0;
		end else begin
			count_q <= count_d;
			state_q <= state_d;
			k_q <= k_d;
			w_q <= w_d;
		end
	end

	// Running best entry of the scan.
	always_ff @(posedge clk) begin
		best_id_q <= best_id_d;
		best_pri_q <= best_pri_d;
	end

	// Storage: a pack write lands at or below the entry just read, never on an unread one.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign nonempty = (count_q != '0);

endmodule
